// File: design/ags_pkg.sv
// Shared types and constants for the automatic gear shift scheduler.
// No dependencies.
package ags_pkg;

  localparam int SPEED_W   = 11;
  localparam int RPM_W     = 14;
  localparam int GEAR_W    = 8;
  localparam int TGEAR_W   = 3;
  localparam int ATTEMPT_W = 10;
  localparam int LIMIT_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int TICK_MS_DEF     = 100;
  localparam int RUNNING_RPM_DEF = 500;
  localparam int TOP_GEAR_DEF    = 4;

  localparam logic [LIMIT_W-1:0]   LIMIT_RST  = 16'd300;
  localparam logic [SPEED_W-1:0]   UP1_RST    = 11'd176;
  localparam logic [SPEED_W-1:0]   UP2_RST    = 11'd352;
  localparam logic [SPEED_W-1:0]   UP3_RST    = 11'd456;
  localparam logic [SPEED_W-1:0]   DN2_RST    = 11'd152;
  localparam logic [SPEED_W-1:0]   DN3_RST    = 11'd312;
  localparam logic [SPEED_W-1:0]   DN4_RST    = 11'd400;
  localparam logic [TGEAR_W-1:0]   GEAR1      = 3'd1;
  localparam logic [TGEAR_W-1:0]   GEAR2      = 3'd2;
  localparam logic [TGEAR_W-1:0]   GEAR3      = 3'd3;
  localparam logic [TGEAR_W-1:0]   GEAR4      = 3'd4;
  localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AUTO_MODE = 3'd0,
    REG_LIMIT_MS  = 3'd1,
    REG_UP1       = 3'd2,
    REG_UP2       = 3'd3,
    REG_UP3       = 3'd4,
    REG_DN2       = 3'd5,
    REG_DN3       = 3'd6,
    REG_DN4       = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ACT_HOLD   = 3'd0,
    ACT_UP     = 3'd1,
    ACT_DOWN   = 3'd2,
    ACT_MANUAL = 3'd3,
    ACT_FORCED = 3'd4
  } action_t;

endpackage

// File: design/automatic_gear_shift_scheduler.sv
// Automatic gear shift scheduler: top level, one module.
// Path of a beat: input register, then result register.
// Throughput: one beat per clock unless out_ready stalls; the decision logic between
// the registers is a handful of compares, one constant multiply, gear/attempt update.
// Reset (rst_n, synchronous): config to defaults, tracked gear 1, attempts 0,
// both pipeline stages empty. Depends on ags_pkg.
module automatic_gear_shift_scheduler #(
  parameter int TICK_MS     = ags_pkg::TICK_MS_DEF,
  parameter int RUNNING_RPM = ags_pkg::RUNNING_RPM_DEF,
  parameter int TOP_GEAR    = ags_pkg::TOP_GEAR_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [ags_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ags_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ags_pkg::SPEED_W-1:0]    in_vehicle_speed,
  input  logic                           in_throttle_active,
  input  logic [ags_pkg::RPM_W-1:0]      in_engine_rpm,
  input  logic [ags_pkg::GEAR_W-1:0]     in_reported_gear,
  input  logic [ags_pkg::GEAR_W-1:0]     in_manual_gear,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ags_pkg::GEAR_W-1:0]     out_gear_command,
  output logic [2:0]                     out_shift_action
);

  // attempts * TICK_MS product width, and the common compare width with the limit
  localparam int TICK_W = $clog2(TICK_MS + 1);
  localparam int PROD_W = ags_pkg::ATTEMPT_W + TICK_W;
  localparam int CMP_W  = (PROD_W > ags_pkg::LIMIT_W) ? PROD_W : ags_pkg::LIMIT_W;

  localparam logic [ags_pkg::RPM_W-1:0]   RUN_RPM = ags_pkg::RPM_W'(RUNNING_RPM);
  localparam logic [ags_pkg::TGEAR_W-1:0] TOP_G   = ags_pkg::TGEAR_W'(TOP_GEAR);
  localparam logic [TICK_W-1:0]           TICK_C  = TICK_W'(TICK_MS);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic                          auto_mode_r;
  logic [ags_pkg::LIMIT_W-1:0]   limit_ms_r;
  logic [ags_pkg::SPEED_W-1:0]   up1_r, up2_r, up3_r;
  logic [ags_pkg::SPEED_W-1:0]   dn2_r, dn3_r, dn4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_mode_r <= 1'b0;
      limit_ms_r  <= ags_pkg::LIMIT_RST;
      up1_r       <= ags_pkg::UP1_RST;
      up2_r       <= ags_pkg::UP2_RST;
      up3_r       <= ags_pkg::UP3_RST;
      dn2_r       <= ags_pkg::DN2_RST;
      dn3_r       <= ags_pkg::DN3_RST;
      dn4_r       <= ags_pkg::DN4_RST;
    end else if (cfg_we) begin
      case (ags_pkg::cfg_reg_t'(cfg_index))
        ags_pkg::REG_AUTO_MODE: auto_mode_r <= cfg_wdata[0];
        ags_pkg::REG_LIMIT_MS:  limit_ms_r  <= cfg_wdata;
        ags_pkg::REG_UP1:       up1_r       <= cfg_wdata[ags_pkg::SPEED_W-1:0];
        ags_pkg::REG_UP2:       up2_r       <= cfg_wdata[ags_pkg::SPEED_W-1:0];
        ags_pkg::REG_UP3:       up3_r       <= cfg_wdata[ags_pkg::SPEED_W-1:0];
        ags_pkg::REG_DN2:       dn2_r       <= cfg_wdata[ags_pkg::SPEED_W-1:0];
        ags_pkg::REG_DN3:       dn3_r       <= cfg_wdata[ags_pkg::SPEED_W-1:0];
        ags_pkg::REG_DN4:       dn4_r       <= cfg_wdata[ags_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Pipeline control: input register feeds the result register.
  // Stage 1 advances whenever the result register is empty or being drained,
  // so a new beat is taken every clock while the consumer keeps up.
  // ---------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic advance;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // input register payload
  logic [ags_pkg::SPEED_W-1:0] speed_r;
  logic                        throttle_r;
  logic [ags_pkg::RPM_W-1:0]   rpm_r;
  logic [ags_pkg::GEAR_W-1:0]  reported_r;
  logic [ags_pkg::GEAR_W-1:0]  manual_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      speed_r    <= in_vehicle_speed;
      throttle_r <= in_throttle_active;
      rpm_r      <= in_engine_rpm;
      reported_r <= in_reported_gear;
      manual_r   <= in_manual_gear;
    end
  end

  // ---------------------------------------------------------------
  // Shift decision
  // ---------------------------------------------------------------
  logic [ags_pkg::TGEAR_W-1:0]   gear_r, gear_nxt;
  logic [ags_pkg::ATTEMPT_W-1:0] attempts_r, attempts_nxt;
  logic [ags_pkg::ATTEMPT_W-1:0] attempts_inc;

  logic [ags_pkg::SPEED_W-1:0] up_thr, dn_thr;
  logic [PROD_W-1:0]           elapsed_ms;
  logic                        forced, do_up, do_down;
  logic [ags_pkg::GEAR_W-1:0]  cmd_nxt;
  ags_pkg::action_t            act_nxt;

  // gears without a threshold register read 0; the gear range checks
  // keep those values out of any decision
  always_comb begin
    case (gear_r)
      ags_pkg::GEAR1: up_thr = up1_r;
      ags_pkg::GEAR2: up_thr = up2_r;
      ags_pkg::GEAR3: up_thr = up3_r;
      default:        up_thr = '0;
    endcase
    case (gear_r)
      ags_pkg::GEAR2: dn_thr = dn2_r;
      ags_pkg::GEAR3: dn_thr = dn3_r;
      ags_pkg::GEAR4: dn_thr = dn4_r;
      default:        dn_thr = '0;
    endcase
  end

  assign elapsed_ms = PROD_W'(attempts_r) * PROD_W'(TICK_C);

  // engine stopped, or the run of attempts has used up the time budget
  assign forced = (rpm_r <= RUN_RPM) ||
                  (CMP_W'(elapsed_ms) >= CMP_W'(limit_ms_r));
  assign do_up   = (speed_r > up_thr) && throttle_r && (gear_r < TOP_G);
  assign do_down = (speed_r < dn_thr) && (gear_r > ags_pkg::GEAR1);

  // saturating attempt count
  assign attempts_inc = (attempts_r == ags_pkg::ATTEMPT_MAX) ? attempts_r
                                                             : attempts_r + 1'b1;

  always_comb begin
    gear_nxt     = gear_r;
    attempts_nxt = attempts_r;
    if (!auto_mode_r) begin
      cmd_nxt = manual_r;
      act_nxt = ags_pkg::ACT_MANUAL;
    end else if (forced) begin
      cmd_nxt      = reported_r;
      act_nxt      = ags_pkg::ACT_FORCED;
      attempts_nxt = '0;
    end else if (do_up) begin
      gear_nxt     = gear_r + 1'b1;
      cmd_nxt      = ags_pkg::GEAR_W'(gear_nxt);
      act_nxt      = ags_pkg::ACT_UP;
      attempts_nxt = attempts_inc;
    end else if (do_down) begin
      gear_nxt     = gear_r - 1'b1;
      cmd_nxt      = ags_pkg::GEAR_W'(gear_nxt);
      act_nxt      = ags_pkg::ACT_DOWN;
      attempts_nxt = attempts_inc;
    end else begin
      cmd_nxt      = ags_pkg::GEAR_W'(gear_r);
      act_nxt      = ags_pkg::ACT_HOLD;
      attempts_nxt = '0;
    end
  end

  // state moves only when a beat passes into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gear_r     <= ags_pkg::GEAR1;
      attempts_r <= '0;
    end else if (advance) begin
      gear_r     <= gear_nxt;
      attempts_r <= attempts_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  logic [ags_pkg::GEAR_W-1:0] cmd_r;
  ags_pkg::action_t           act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cmd_r <= cmd_nxt;
      act_r <= act_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_gear_command = cmd_r;
  assign out_shift_action = act_r;

endmodule

// File: dv/automatic_gear_shift_scheduler_tb.sv
// Testbench for automatic_gear_shift_scheduler: drives shift ticks in random bursts,
// predicts gear command and shift action per tick and checks every result beat.
// Depends on ags_pkg and the automatic_gear_shift_scheduler RTL.
`timescale 1ns / 100ps

module automatic_gear_shift_scheduler_tb;

  localparam int CYCLE_LIMIT = 300000;  // well above the slowest legal run
  localparam int DRAIN_CYCLES = 6;      // margin after the pipe has drained

  typedef struct {
    logic [ags_pkg::SPEED_W-1:0] speed;
    logic                        throttle;
    logic [ags_pkg::RPM_W-1:0]   rpm;
    logic [ags_pkg::GEAR_W-1:0]  reported;
    logic [ags_pkg::GEAR_W-1:0]  manual;
  } shift_tick_t;

  typedef struct {
    logic [ags_pkg::GEAR_W-1:0] gear_out;
    ags_pkg::action_t           action;
  } shift_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [ags_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ags_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_ready;
  logic [ags_pkg::SPEED_W-1:0]    in_vehicle_speed;
  logic                           in_throttle_active;
  logic [ags_pkg::RPM_W-1:0]      in_engine_rpm;
  logic [ags_pkg::GEAR_W-1:0]     in_reported_gear;
  logic [ags_pkg::GEAR_W-1:0]     in_manual_gear;
  logic                           out_valid;
  logic                           out_ready;
  logic [ags_pkg::GEAR_W-1:0]     out_gear_command;
  logic [2:0]                     out_shift_action;

  // Scheduler model: config copy and state, updated at config writes and
  // at each accepted input beat.
  logic                          auto_en;
  logic [ags_pkg::LIMIT_W-1:0]   limit_ms;
  logic [ags_pkg::SPEED_W-1:0]   up_speed [1:3];
  logic [ags_pkg::SPEED_W-1:0]   dn_speed [2:4];
  logic [ags_pkg::TGEAR_W-1:0]   gear_now;
  logic [ags_pkg::ATTEMPT_W-1:0] attempts;

  shift_result_t expected_shifts[$];
  int            errors = 0;
  int            cycle_cnt = 0;
  int            burst_left = 0;

  automatic_gear_shift_scheduler u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_vehicle_speed   (in_vehicle_speed),
    .in_throttle_active (in_throttle_active),
    .in_engine_rpm      (in_engine_rpm),
    .in_reported_gear   (in_reported_gear),
    .in_manual_gear     (in_manual_gear),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_gear_command   (out_gear_command),
    .out_shift_action   (out_shift_action)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("automatic_gear_shift_scheduler_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------
  task automatic reset_model();
    auto_en     = 1'b0;
    limit_ms    = ags_pkg::LIMIT_RST;
    up_speed[1] = ags_pkg::UP1_RST;
    up_speed[2] = ags_pkg::UP2_RST;
    up_speed[3] = ags_pkg::UP3_RST;
    dn_speed[2] = ags_pkg::DN2_RST;
    dn_speed[3] = ags_pkg::DN3_RST;
    dn_speed[4] = ags_pkg::DN4_RST;
    gear_now    = ags_pkg::GEAR1;
    attempts    = '0;
  endtask

  // Register writes keep the low bits of the data word that fit the register.
  task automatic apply_reg(ags_pkg::cfg_reg_t idx, logic [ags_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      ags_pkg::REG_AUTO_MODE: auto_en     = data[0];
      ags_pkg::REG_LIMIT_MS:  limit_ms    = data[ags_pkg::LIMIT_W-1:0];
      ags_pkg::REG_UP1:       up_speed[1] = data[ags_pkg::SPEED_W-1:0];
      ags_pkg::REG_UP2:       up_speed[2] = data[ags_pkg::SPEED_W-1:0];
      ags_pkg::REG_UP3:       up_speed[3] = data[ags_pkg::SPEED_W-1:0];
      ags_pkg::REG_DN2:       dn_speed[2] = data[ags_pkg::SPEED_W-1:0];
      ags_pkg::REG_DN3:       dn_speed[3] = data[ags_pkg::SPEED_W-1:0];
      ags_pkg::REG_DN4:       dn_speed[4] = data[ags_pkg::SPEED_W-1:0];
      default: ;
    endcase
  endtask

  function automatic void bump_attempts();
    if (attempts != ags_pkg::ATTEMPT_MAX) attempts++;
  endfunction

  // One shift tick: decide command and action, advance gear and attempt count.
  function automatic shift_result_t plan_shift(shift_tick_t t);
    shift_result_t               r;
    logic [ags_pkg::SPEED_W-1:0] up_th;
    logic [ags_pkg::SPEED_W-1:0] dn_th;
    int unsigned                 spent_ms;
    up_th = '0;
    dn_th = '0;
    // gear 1 has no downshift threshold, top gear none for upshift
    case (gear_now)
      ags_pkg::GEAR1: up_th = up_speed[1];
      ags_pkg::GEAR2: begin
        up_th = up_speed[2];
        dn_th = dn_speed[2];
      end
      ags_pkg::GEAR3: begin
        up_th = up_speed[3];
        dn_th = dn_speed[3];
      end
      ags_pkg::GEAR4: dn_th = dn_speed[4];
      default: ;
    endcase
    spent_ms = attempts * ags_pkg::TICK_MS_DEF;
    if (!auto_en) begin
      r.gear_out = t.manual;
      r.action   = ags_pkg::ACT_MANUAL;
    end else if (t.rpm <= ags_pkg::RUNNING_RPM_DEF || spent_ms >= limit_ms) begin
      // engine stopped or shifting took too long: follow the transmission
      r.gear_out = t.reported;
      r.action   = ags_pkg::ACT_FORCED;
      attempts   = '0;
    end else if (t.speed > up_th && t.throttle && gear_now < ags_pkg::TOP_GEAR_DEF) begin
      gear_now   = gear_now + 1'b1;
      r.gear_out = ags_pkg::GEAR_W'(gear_now);
      r.action   = ags_pkg::ACT_UP;
      bump_attempts();
    end else if (t.speed < dn_th && gear_now > ags_pkg::GEAR1) begin
      gear_now   = gear_now - 1'b1;
      r.gear_out = ags_pkg::GEAR_W'(gear_now);
      r.action   = ags_pkg::ACT_DOWN;
      bump_attempts();
    end else begin
      r.gear_out = ags_pkg::GEAR_W'(gear_now);
      r.action   = ags_pkg::ACT_HOLD;
      attempts   = '0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  function automatic shift_tick_t make_tick(int speed, bit thr, int rpm, int rep, int man);
    shift_tick_t t;
    t.speed    = ags_pkg::SPEED_W'(speed);
    t.throttle = thr;
    t.rpm      = ags_pkg::RPM_W'(rpm);
    t.reported = ags_pkg::GEAR_W'(rep);
    t.manual   = ags_pkg::GEAR_W'(man);
    return t;
  endfunction

  function automatic shift_tick_t noise_tick();
    return make_tick($urandom, 1'($urandom), $urandom, $urandom, $urandom);
  endfunction

  task automatic drive_payload(shift_tick_t t);
    in_vehicle_speed   = t.speed;
    in_throttle_active = t.throttle;
    in_engine_rpm      = t.rpm;
    in_reported_gear   = t.reported;
    in_manual_gear     = t.manual;
  endtask

  // Send one tick. The sender runs in bursts; at the start of a burst it may
  // drop valid for a random gap, with junk on the payload meanwhile.
  task automatic send_tick(shift_tick_t t);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        drive_payload(noise_tick());
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    drive_payload(t);
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_shifts.push_back(plan_shift(t));
  endtask

  // Let everything in flight come out, then idle for DRAIN_CYCLES.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (expected_shifts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(ags_pkg::cfg_reg_t idx, logic [ags_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // 11-bit threshold with junk in the unused upper bits of the data word
  function automatic logic [ags_pkg::CFG_DATA_W-1:0] speed_word(int v);
    return {5'($urandom), ags_pkg::SPEED_W'(v)};
  endfunction

  // Mostly running engine and throttle on; speeds often near a live threshold
  // so that shifts happen both ways.
  function automatic shift_tick_t random_tick();
    shift_tick_t t;
    int          pick;
    int          th;
    int          sp;
    t = noise_tick();
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      th = (pick < 3) ? int'(up_speed[pick + 1]) : int'(dn_speed[pick - 1]);
      sp = th + $urandom_range(0, 8) - 4;
      if (sp < 0) sp = 0;
      if (sp > 2047) sp = 2047;
      t.speed = ags_pkg::SPEED_W'(sp);
    end
    t.throttle = ($urandom_range(0, 3) != 0);
    pick = $urandom_range(0, 19);
    if (pick < 17) begin
      t.rpm = ags_pkg::RPM_W'($urandom_range(ags_pkg::RUNNING_RPM_DEF + 1, 16383));
    end else if (pick < 19) begin
      t.rpm = ags_pkg::RPM_W'($urandom_range(0, ags_pkg::RUNNING_RPM_DEF));
    end else begin
      t.rpm = ags_pkg::RPM_W'(ags_pkg::RUNNING_RPM_DEF + $urandom_range(0, 1));
    end
    return t;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker and receiver stalls
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    shift_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_shifts.size() == 0) begin
        $error("result beat with nothing expected: gear_command=%0d shift_action=%0d",
               out_gear_command, out_shift_action);
        errors++;
      end else begin
        exp_r = expected_shifts.pop_front();
        if (out_gear_command !== exp_r.gear_out) begin
          $error("gear_command: expected %0d, got %0d", exp_r.gear_out, out_gear_command);
          errors++;
        end
        if (out_shift_action !== exp_r.action) begin
          $error("shift_action: expected %0d, got %0d", exp_r.action, out_shift_action);
          errors++;
        end
      end
    end
  end

  // Receiver: segments of always-ready, random stalls and a fixed duty pattern.
  initial begin
    int mode;
    int len;
    int k;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(20, 120);
      for (k = 0; k < len; k++) begin
        @(negedge clk);
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = ($urandom_range(0, 99) >= 35);
          default: out_ready = (k % 5 < 3);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Manual mode after reset: joystick gear passes, state must stay put.
  task automatic test_manual_passthrough();
    send_tick(make_tick(2047, 1, 16383, 0, 255));
    send_tick(make_tick(0, 0, 0, 255, 0));
    send_tick(make_tick(176, 1, 500, 170, 85));
    repeat (37) send_tick(random_tick());
    drain();
  endtask

  // Directed walk through the hold, up, down and forced actions with the reset thresholds.
  task automatic test_directed_shifts();
    write_reg(ags_pkg::REG_AUTO_MODE, 16'h0001);
    send_tick(make_tick(0, 1, 500, 0, 255));       // rpm at running limit -> forced
    send_tick(make_tick(0, 1, 0, 255, 0));         // engine stopped
    send_tick(make_tick(176, 1, 501, 3, 3));       // speed equal to threshold -> hold
    send_tick(make_tick(2047, 0, 501, 3, 3));      // no throttle -> hold
    send_tick(make_tick(177, 1, 16383, 1, 1));     // 1 -> 2
    send_tick(make_tick(2047, 1, 600, 2, 2));      // 2 -> 3
    send_tick(make_tick(2047, 1, 600, 3, 3));      // 3 -> 4
    send_tick(make_tick(2047, 1, 600, 200, 9));    // three attempts used up -> forced
    send_tick(make_tick(2047, 1, 16383, 4, 4));    // top gear, no upshift
    send_tick(make_tick(400, 1, 9000, 4, 4));      // equal to downshift threshold
    send_tick(make_tick(399, 0, 9000, 4, 4));      // 4 -> 3
    send_tick(make_tick(0, 0, 9000, 3, 3));        // 3 -> 2
    send_tick(make_tick(151, 0, 9000, 2, 2));      // 2 -> 1
    send_tick(make_tick(0, 1, 9000, 77, 7));       // attempts exhausted again
    send_tick(make_tick(0, 0, 9000, 1, 1));        // gear 1 never downshifts
    send_tick(make_tick(1024, 1, 8192, 128, 64));
    drain();
    // zero limit: every running tick is forced
    write_reg(ags_pkg::REG_LIMIT_MS, 16'h0000);
    send_tick(make_tick(2047, 1, 16383, 255, 1));
    send_tick(make_tick(1, 1, 501, 0, 1));
    drain();
  endtask

  // Thresholds that shift on every tick, so the attempt count climbs until
  // the maximum time limit cuts it off, then starts over.
  task automatic test_attempt_chain();
    shift_tick_t t;
    write_reg(ags_pkg::REG_AUTO_MODE, 16'h0001);
    write_reg(ags_pkg::REG_LIMIT_MS, 16'hFFFF);
    write_reg(ags_pkg::REG_UP1, speed_word(0));
    write_reg(ags_pkg::REG_UP2, speed_word(2047));
    write_reg(ags_pkg::REG_DN2, speed_word(2047));
    write_reg(ags_pkg::REG_UP3, speed_word(2047));
    write_reg(ags_pkg::REG_DN3, speed_word(2047));
    write_reg(ags_pkg::REG_DN4, speed_word(2047));
    repeat (700) begin
      t = noise_tick();
      t.speed    = ags_pkg::SPEED_W'($urandom_range(1, 2046));
      t.throttle = 1'b1;
      t.rpm      = ags_pkg::RPM_W'($urandom_range(ags_pkg::RUNNING_RPM_DEF + 1, 16383));
      send_tick(t);
    end
    drain();
  endtask

  // Several register settings, extremes first, each followed by random ticks.
  task automatic test_random_settings();
    int ph;
    int up1;
    int up2;
    int up3;
    int lim;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin up1 = 0;    up2 = 0;    up3 = 0;    lim = 65535; end
        1: begin up1 = 2047; up2 = 2047; up3 = 2047; lim = 0;     end
        2: begin
          up1 = $urandom_range(0, 2047);
          up2 = $urandom_range(0, 2047);
          up3 = $urandom_range(0, 2047);
          lim = $urandom_range(0, 65535);
        end
        default: begin
          up1 = $urandom_range(100, 300);
          up2 = $urandom_range(300, 600);
          up3 = $urandom_range(600, 1000);
          lim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(100, 1500);
        end
      endcase
      // phase 2 runs in manual mode with shifting state left over
      write_reg(ags_pkg::REG_AUTO_MODE, {15'($urandom), ph != 2});
      write_reg(ags_pkg::REG_LIMIT_MS, 16'(lim));
      write_reg(ags_pkg::REG_UP1, speed_word(up1));
      write_reg(ags_pkg::REG_UP2, speed_word(up2));
      write_reg(ags_pkg::REG_UP3, speed_word(up3));
      if (ph < 3) begin
        write_reg(ags_pkg::REG_DN2, speed_word(up1));
        write_reg(ags_pkg::REG_DN3, speed_word(up2));
        write_reg(ags_pkg::REG_DN4, speed_word(up3));
      end else begin
        write_reg(ags_pkg::REG_DN2, speed_word($urandom_range(50, up1)));
        write_reg(ags_pkg::REG_DN3, speed_word($urandom_range(up1, up2)));
        write_reg(ags_pkg::REG_DN4, speed_word($urandom_range(up2, up3)));
      end
      repeat (115) send_tick(random_tick());
      drain();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = ags_pkg::REG_AUTO_MODE;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    drive_payload(make_tick(0, 0, 0, 0, 0));
    reset_model();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_manual_passthrough();
    test_directed_shifts();
    test_attempt_chain();
    test_random_settings();

    while (expected_shifts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("automatic_gear_shift_scheduler_tb passed");
    end else begin
      $display("automatic_gear_shift_scheduler_tb failed");
    end
    $finish;
  end

endmodule
